@@ design/pstg_pkg.sv @@
// shared types, constants and sine table builder for the pcm sine tone generator
package pstg_pkg;

    // defaults for the top level parameters
    localparam int MAX_CHANNELS_DEF    = 8;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // depth of the queue between the phase front end and the sample back end
    localparam int QUEUE_DEPTH = 2;

    // pi/2 in q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // configuration register widths
    localparam int PHASE_W = 32;
    localparam int CHCNT_W = 4;
    localparam int CFG_W   = 32;

    // table entries are unsigned q0.31 below one
    localparam int MAG_W = 31;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PHASE_INC     = 2'd0,
        CFG_NUM_CHANNELS  = 2'd1,
        CFG_SAMPLE_FORMAT = 2'd2
    } pstg_cfg_idx_t;

    // sample format codes, the unused code behaves as 32 bit
    typedef enum logic [1:0] {
        FMT_16 = 2'd0,
        FMT_24 = 2'd1,
        FMT_32 = 2'd2
    } pstg_fmt_t;

    // configuration seen by the front and back ends
    typedef struct packed {
        logic [PHASE_W-1:0] phase_inc;
        logic [CHCNT_W-1:0] num_channels;
        pstg_fmt_t          sample_format;
    } pstg_cfg_t;

    // queue status toward the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } pstg_q_stat_t;

    // one taylor term divided by (2n)(2n+1)
    function automatic logic [63:0] pstg_term_div(input logic [63:0] t, input int n);
        logic [63:0] q;
        case (n)
            1:       q = t / 64'd6;
            2:       q = t / 64'd20;
            3:       q = t / 64'd42;
            4:       q = t / 64'd72;
            5:       q = t / 64'd110;
            6:       q = t / 64'd156;
            7:       q = t / 64'd210;
            default: q = t / 64'd272;
        endcase
        return q;
    endfunction

    // quarter wave sine entry k of a table with 2^tbits steps, evaluated at elaboration
    function automatic logic [MAG_W-1:0] pstg_sine_entry(input int unsigned k,
                                                         input int unsigned tbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (64'(k) * HALF_PI_Q30) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 8; n++) begin
            term = pstg_term_div((term * x2) >> 30, n);
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        v = unsigned'(sum) << 1;
        if (v > 64'h7FFF_FFFF)
            v = 64'h7FFF_FFFF;
        return v[MAG_W-1:0];
    endfunction

endpackage

@@ design/pstg_front.sv @@
// front end: takes frame requests, owns the phase accumulator, queues table lookups
module pstg_front
    import pstg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    localparam int ADDR_W = SINE_TABLE_BITS + 1,
    localparam int ENTRY_W = ADDR_W + 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               frame_request,
    input  logic [PHASE_W-1:0] phase_inc,
    input  pstg_q_stat_t       q_stat,
    output logic               push,
    output logic [ENTRY_W-1:0] push_data
);

    localparam logic [ADDR_W-1:0] FULL_SCALE = ADDR_W'(1) << SINE_TABLE_BITS;

    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         phase_next;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ADDR_W-1:0]          addr;
    logic                       accept;

    // transaction handshake, the queue decides when to hold off
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign push     = accept && frame_request;

    // quadrant folding onto the quarter wave table
    assign quad = phase_reg[PHASE_W-1 -: 2];
    assign idx  = phase_reg[PHASE_W-3 -: SINE_TABLE_BITS];
    assign addr = quad[0] ? (FULL_SCALE - ADDR_W'(idx)) : ADDR_W'(idx);

    // entry: sign in the top bit, table address below
    assign push_data = {quad[1], addr};

    // phase advances once per requested frame
    always_comb
    begin
        phase_next = phase_reg;
        if (push)
            phase_next = phase_reg + phase_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

endmodule

@@ design/pstg_queue.sv @@
// small fifo between the front end and the back end
module pstg_queue
    import pstg_pkg::*;
#(
    parameter int WIDTH = 12,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output pstg_q_stat_t     stat
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ design/pstg_back.sv @@
// back end: table lookup, scaling, and byte serialization over the channels
module pstg_back
    import pstg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int ADDR_W = SINE_TABLE_BITS + 1,
    localparam int ENTRY_W = ADDR_W + 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pstg_q_stat_t       q_stat,
    input  logic [ENTRY_W-1:0] pop_data,
    output logic               pop,
    input  pstg_cfg_t          cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         data_byte,
    output logic [2:0]         channel_index,
    output logic               frame_last
);

    localparam int ROM_DEPTH = 2 ** ADDR_W;
    localparam int TABLE_LEN = 2 ** SINE_TABLE_BITS + 1;
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W = $clog2(MAX_CHANNELS + 1) + 1;
    localparam int PROD_W = 2 * MAG_W;

    // quarter wave table, entries past the quarter never get addressed
    logic [MAG_W-1:0] rom_w [ROM_DEPTH];

    for (genvar gk = 0; gk < ROM_DEPTH; gk++)
    begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY =
            (gk < TABLE_LEN) ? pstg_sine_entry(gk, SINE_TABLE_BITS) : '0;
        assign rom_w[gk] = ENTRY;
    end

    logic              a_valid_reg;
    logic              a_valid_next;
    logic [MAG_W-1:0]  mag_reg;
    logic              a_neg_reg;
    logic              b_valid_reg;
    logic              b_valid_next;
    logic [PROD_W-1:0] prod_reg;
    logic              b_neg_reg;
    logic              c_valid_reg;
    logic              c_valid_next;
    logic [31:0]       sample_reg;
    logic [31:0]       sample_next;
    logic [CH_W-1:0]   ch_reg;
    logic [CH_W-1:0]   ch_next;
    logic [1:0]        byte_reg;
    logic [1:0]        byte_next;
    logic              a_take;
    logic              b_take;
    logic              c_load;
    logic              out_fire;
    logic [MAG_W-1:0]  max_val;
    logic [1:0]        last_byte;
    logic [NCH_W-1:0]  nch;
    logic [NCH_W-1:0]  last_ch;
    logic              ch_is_last;
    logic              byte_is_last;
    logic [31:0]       scaled;

    // stage advance chain from the output back to the queue
    assign out_fire = c_valid_reg && !out_stall;
    assign c_load   = !c_valid_reg || (out_fire && frame_last);
    assign b_take   = !b_valid_reg || c_load;
    assign a_take   = !a_valid_reg || b_take;
    assign pop      = !q_stat.empty && a_take;

    // sample format decode
    always_comb
    begin
        case (cfg.sample_format)
            FMT_16:
            begin
                max_val   = MAG_W'(32'h0000_7FFF);
                last_byte = 2'd1;
            end
            FMT_24:
            begin
                max_val   = MAG_W'(32'h007F_FFFF);
                last_byte = 2'd2;
            end
            default:
            begin
                max_val   = MAG_W'(32'h7FFF_FFFF);
                last_byte = 2'd3;
            end
        endcase
    end

    // effective channel count, zero means one, clamped to the maximum
    always_comb
    begin
        if (cfg.num_channels == '0)
            nch = NCH_W'(1);
        else if (NCH_W'(cfg.num_channels) > NCH_W'(MAX_CHANNELS))
            nch = NCH_W'(MAX_CHANNELS);
        else
            nch = NCH_W'(cfg.num_channels);
    end

    assign last_ch      = nch - 1'b1;
    assign ch_is_last   = (NCH_W'(ch_reg) == last_ch);
    assign byte_is_last = (byte_reg == last_byte);

    // truncated magnitude, sign applied after scaling
    assign scaled = 32'(prod_reg[PROD_W-1:MAG_W]);

    // valid flags of the three stages
    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        c_valid_next = c_valid_reg;
        if (a_take)
            a_valid_next = pop;
        if (b_take)
            b_valid_next = a_valid_reg;
        if (c_load)
            c_valid_next = b_valid_reg;
    end

    // serializer position and held sample
    always_comb
    begin
        sample_next = sample_reg;
        ch_next     = ch_reg;
        byte_next   = byte_reg;
        if (c_load)
        begin
            if (b_valid_reg)
            begin
                sample_next = b_neg_reg ? (32'd0 - scaled) : scaled;
                ch_next     = '0;
                byte_next   = '0;
            end
        end
        else if (out_fire)
        begin
            if (byte_is_last)
            begin
                byte_next = '0;
                ch_next   = ch_reg + 1'b1;
            end
            else
            begin
                byte_next = byte_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            ch_reg      <= '0;
            byte_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            ch_reg      <= ch_next;
            byte_reg    <= byte_next;
        end
    end

    // registered table read, then registered scaling product
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mag_reg   <= rom_w[pop_data[ADDR_W-1:0]];
            a_neg_reg <= pop_data[ENTRY_W-1];
        end
        if (b_take && a_valid_reg)
        begin
            prod_reg  <= PROD_W'(mag_reg) * PROD_W'(max_val);
            b_neg_reg <= a_neg_reg;
        end
        sample_reg <= sample_next;
    end

    // result transaction fields
    assign out_valid     = c_valid_reg;
    assign data_byte     = 8'(sample_reg >> {byte_reg, 3'b000});
    assign channel_index = 3'(ch_reg);
    assign frame_last    = ch_is_last && byte_is_last;

endmodule

@@ design/pcm_sine_tone_generator.sv @@
// top level of the pcm sine tone generator: configuration registers and block wiring
//
// Direct digital synthesis sine source. Each frame request transaction advances a
// 32-bit phase accumulator (one turn is 2^32) by phase_increment and yields one PCM
// frame: the sine at the phase held before the step, looked up in a quarter-wave
// table without interpolation, scaled to 16, 24 or 32 bits with truncation toward
// zero, sent for every channel as little-endian bytes, channel 0 first, with
// frame_last on the final byte. Requests with frame_request low are taken and
// produce nothing. Results leave at one byte per cycle while out_stall is low; a
// frame is channels times bytes-per-sample bytes (2 to 32 with eight channels);
// the byte serializer at the output sets the sustained rate, and a new request is
// taken in any cycle while the two-entry queue has room. When the pipeline is empty,
// a frame's first byte passes the queue and the table, scaling and serializer
// registers first. The sine table is constant logic, so there is no start-up sweep.
// Configuration must be written only while the block is idle; nothing enforces it.
module pcm_sine_tone_generator
    import pstg_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             frame_request,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       data_byte,
    output logic [2:0]       channel_index,
    output logic             frame_last
);

    localparam int ENTRY_W = SINE_TABLE_BITS + 2;

    pstg_cfg_t          cfg_reg;
    pstg_cfg_t          cfg_next;
    pstg_q_stat_t       q_stat;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] pop_data;

    // configuration register writes, unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (pstg_cfg_idx_t'(cfg_index))
                CFG_PHASE_INC:     cfg_next.phase_inc     = cfg_data[PHASE_W-1:0];
                CFG_NUM_CHANNELS:  cfg_next.num_channels  = cfg_data[CHCNT_W-1:0];
                CFG_SAMPLE_FORMAT: cfg_next.sample_format = pstg_fmt_t'(cfg_data[1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_inc     <= 32'h1000_0000;
            cfg_reg.num_channels  <= CHCNT_W'(2);
            cfg_reg.sample_format <= FMT_16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // phase front end
    pstg_front #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame_request (frame_request),
        .phase_inc     (cfg_reg.phase_inc),
        .q_stat        (q_stat),
        .push          (push),
        .push_data     (push_data)
    );

    // lookup queue
    pstg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // sample back end
    pstg_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .MAX_CHANNELS    (MAX_CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_data      (pop_data),
        .pop           (pop),
        .cfg           (cfg_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .channel_index (channel_index),
        .frame_last    (frame_last)
    );

`ifndef NO_ASSERTIONS
    // queue can never report full and empty together
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    // back end only pulls from a queue that holds an entry
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("back end popped an empty queue");

    // a requested frame is visible in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && frame_request) |=> !q_stat.empty)
        else $error("accepted frame request did not reach the queue");
`endif

endmodule
